### design/ps2mc_pkg.sv
`default_nettype none

package ps2mc_pkg;

  // Field widths of the streams and registers.
  localparam int unsigned DataW   = 8;
  localparam int unsigned ColW    = 7;
  localparam int unsigned LineW   = 5;
  localparam int unsigned OutW    = 16;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned ApbW    = 32;

  // Default sensitivity divisor (range 1 to 16).
  localparam int unsigned DivisorDefault = 4;

  // Register reset values.
  localparam logic [ColW-1:0]  MaxColumnReset = 7'd79;
  localparam logic [LineW-1:0] MaxLineReset   = 5'd24;
  localparam logic [ColW-1:0]  PosXReset      = 7'd40;
  localparam logic [LineW-1:0] PosYReset      = 5'd12;

  // Header bit positions.
  localparam int unsigned HdrLeftBit  = 0;
  localparam int unsigned HdrXSignBit = 4;
  localparam int unsigned HdrYSignBit = 5;

  // Packet byte positions.
  localparam logic [1:0] PosHeader = 2'd0;
  localparam logic [1:0] PosX      = 2'd1;
  localparam logic [1:0] PosY      = 2'd2;

  // Register indexes, taken from the word address.
  localparam logic RegMaxColumn = 1'b0;
  localparam logic RegMaxLine   = 1'b1;

endpackage

`default_nettype wire

### design/ps2_mouse_cursor_tracker.sv
// A result item appears on m_tdata in the cycle after the third flagged byte is accepted.
// One byte per cycle is taken while s_tready is high; s_tready drops only while a result waits unaccepted.
// The per-byte path is one constant multiply (reciprocal of DIVISOR), one add and a clamp.
// Reset (synchronous, active high) sets the cursor to column 40, row 12, clears the packet
// position and restores max_column to 79 and max_line to 24.
`default_nettype none

module ps2_mouse_cursor_tracker #(
  parameter int unsigned DIVISOR = ps2mc_pkg::DivisorDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Input stream.
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [ps2mc_pkg::DataW-1:0] s_tdata,  // [7:0] data_byte
  input  wire logic                        s_tuser,  // [0] aux_flag
  // Result stream.
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [ps2mc_pkg::OutW-1:0]       m_tdata,  // [6:0] cursor_x, [11:7] cursor_y,
                                                     // [12] left_button, [15:13] zero
  // Register port. The byte offset within a word is ignored.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ps2mc_pkg::AddrW-1:0] paddr,
  input  wire logic [ps2mc_pkg::ApbW-1:0]  pwdata,
  output logic [ps2mc_pkg::ApbW-1:0]       prdata,
  output logic                             pready
);
  import ps2mc_pkg::*;

  // Division by DIVISOR as a multiply by a rounded-up reciprocal; exact for magnitudes
  // up to 256 and divisors up to 16.
  localparam int unsigned RecipShift = 16;
  localparam int unsigned RecipVal   = ((1 << RecipShift) + DIVISOR - 1) / DIVISOR;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned MagW       = 9;
  localparam int unsigned ProdW      = MagW + RecipW;
  localparam int unsigned SumW       = 11;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipVal);

  logic [ColW-1:0]  max_column;
  logic [LineW-1:0] max_line;
  logic [1:0]       byte_position;
  logic [DataW-1:0] header_byte;
  logic [DataW-1:0] x_byte;
  logic [ColW-1:0]  pos_x;
  logic [ColW-1:0]  pos_x_next;
  logic [LineW-1:0] pos_y;
  logic [LineW-1:0] pos_y_next;
  logic             left_button;
  logic             out_valid;

  logic             in_fire;
  logic             flag_fire;
  logic             packet_done;
  logic             cfg_write;

  logic [MagW-1:0]  mag_x;
  logic [MagW-1:0]  mag_y;
  logic [ProdW-1:0] prod_x;
  logic [ProdW-1:0] prod_y;
  logic [MagW-1:0]  quot_x;
  logic [MagW-1:0]  quot_y;
  logic signed [SumW-1:0] step_x;
  logic signed [SumW-1:0] step_y;
  logic signed [SumW-1:0] new_x;
  logic signed [SumW-1:0] new_y;

  // Handshakes.
  assign s_tready    = !out_valid || m_tready;
  assign in_fire     = s_tvalid && s_tready;
  assign flag_fire   = in_fire && s_tuser;
  assign packet_done = flag_fire && (byte_position != PosHeader) && (byte_position != PosX);
  assign cfg_write   = psel && penable && pwrite && pready;
  assign pready      = 1'b1;

  // Movement magnitudes: the 9-bit value is sign bit over data byte.
  always_comb begin
    mag_x = header_byte[HdrXSignBit] ? MagW'(9'd256 - {1'b0, x_byte}) : {1'b0, x_byte};
    mag_y = header_byte[HdrYSignBit] ? MagW'(9'd256 - {1'b0, s_tdata}) : {1'b0, s_tdata};
  end

  // Truncating division of the magnitudes, then the sign is put back.
  always_comb begin
    prod_x = ProdW'(mag_x) * ProdW'(Recip);
    prod_y = ProdW'(mag_y) * ProdW'(Recip);
    quot_x = prod_x[RecipShift +: MagW];
    quot_y = prod_y[RecipShift +: MagW];
    step_x = header_byte[HdrXSignBit] ? -$signed(SumW'(quot_x)) : $signed(SumW'(quot_x));
    step_y = header_byte[HdrYSignBit] ? -$signed(SumW'(quot_y)) : $signed(SumW'(quot_y));
  end

  // New position, clamped to zero and to the configured maximum.
  always_comb begin
    new_x = $signed(SumW'(pos_x)) + step_x;
    new_y = $signed(SumW'(pos_y)) - step_y;
    if (new_x < 0) begin
      pos_x_next = '0;
    end else if (new_x > $signed(SumW'(max_column))) begin
      pos_x_next = max_column;
    end else begin
      pos_x_next = new_x[ColW-1:0];
    end
    if (new_y < 0) begin
      pos_y_next = '0;
    end else if (new_y > $signed(SumW'(max_line))) begin
      pos_y_next = max_line;
    end else begin
      pos_y_next = new_y[LineW-1:0];
    end
  end

  // Packet collection and cursor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= PosHeader;
      header_byte   <= '0;
      x_byte        <= '0;
      pos_x         <= PosXReset;
      pos_y         <= PosYReset;
      left_button   <= 1'b0;
    end else if (flag_fire) begin
      unique case (byte_position)
        PosHeader: begin
          header_byte   <= s_tdata;
          byte_position <= PosX;
        end
        PosX: begin
          x_byte        <= s_tdata;
          byte_position <= PosY;
        end
        default: begin
          byte_position <= PosHeader;
          pos_x         <= pos_x_next;
          pos_y         <= pos_y_next;
          left_button   <= header_byte[HdrLeftBit];
        end
      endcase
    end
  end

  // Result register valid flag; the payload is the cursor state itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (packet_done) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OutW'({left_button, pos_y, pos_x});

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_column <= MaxColumnReset;
      max_line   <= MaxLineReset;
    end else if (cfg_write) begin
      unique case (paddr[2])
        RegMaxColumn: max_column <= pwdata[ColW-1:0];
        RegMaxLine:   max_line   <= pwdata[LineW-1:0];
        default:      max_line   <= max_line;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      RegMaxColumn: prdata = ApbW'(max_column);
      RegMaxLine:   prdata = ApbW'(max_line);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire
